// ----- src/gae_pkg.sv -----
// ----------------------------------------------------------------------------
// gae_pkg
// Types and constants shared by the airspeed estimator and its serial units.
// ----------------------------------------------------------------------------
package gae_pkg;

  typedef struct packed {
    logic signed [15:0] fuse_x;
    logic signed [15:0] fuse_y;
    logic signed [15:0] fuse_z;
    logic signed [15:0] vel_north;
    logic signed [15:0] vel_east;
    logic signed [15:0] vel_down;
    logic        [10:0] air_density;
  } item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [14:0] tas_filtered;
    logic [15:0] calibrated_airspeed;
  } result_t;

  // Result status codes.
  localparam logic [1:0] STATUS_TURN_SMALL    = 2'd0;
  localparam logic [1:0] STATUS_PUBLISHED     = 2'd1;
  localparam logic [1:0] STATUS_NOT_PUBLISHED = 2'd2;
  localparam logic [1:0] STATUS_REJECTED      = 2'd3;

  // Register indexes.
  localparam logic [1:0] REG_COS_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_MAX_SPEED     = 2'd1;
  localparam logic [1:0] REG_FILTER_GAIN   = 2'd2;
  localparam logic [1:0] REG_READ_ONLY     = 2'd3;

  // Serial multiplier: parallel operand, serial operand, product.
  localparam int MUL_AW = 32;
  localparam int MUL_BW = 17;
  localparam int MUL_PW = MUL_AW + MUL_BW;

  // Divider: denominator and kept quotient widths.
  localparam int DEN_W = 34;
  localparam int QUO_W = 31;

  // Density of sea-level air in g/m^3.
  localparam logic [DEN_W-1:0] SEA_LEVEL_DENSITY = 34'd1225;

  function automatic logic [16:0] abs17(input logic signed [16:0] v);
    logic [16:0] r;
    r = v[16] ? 17'(-v) : 17'(v);
    return r;
  endfunction

endpackage

// ----- src/gae_serial_mul.sv -----
// ----------------------------------------------------------------------------
// gae_serial_mul
// Shift-add multiplier taking one bit of the serial operand per cycle.
// ----------------------------------------------------------------------------
module gae_serial_mul (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [gae_pkg::MUL_AW-1:0] a,
  input  logic [gae_pkg::MUL_BW-1:0] b,
  output logic                       done,
  output logic [gae_pkg::MUL_PW-1:0] prod
);
  import gae_pkg::*;

  localparam int CNT_W = $clog2(MUL_BW + 1);

  logic [MUL_PW-1:0] areg;
  logic [MUL_BW-1:0] breg;
  logic [CNT_W-1:0]  cnt;
  logic              busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(MUL_BW);
        prod <= '0;
        areg <= MUL_PW'(a);
        breg <= b;
      end else if (busy) begin
        if (breg[0]) begin
          prod <= prod + areg;
        end
        areg <= areg << 1;
        breg <= breg >> 1;
        cnt  <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- src/gae_serial_div.sv -----
// ----------------------------------------------------------------------------
// gae_serial_div
// Restoring divider, one numerator bit per cycle. Quotient bits that fall
// above the kept width raise the overflow flag.
// ----------------------------------------------------------------------------
module gae_serial_div #(
  parameter int NUM_W = 62
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [NUM_W-1:0]          num,
  input  logic [gae_pkg::DEN_W-1:0] den,
  output logic                      done,
  output logic [gae_pkg::QUO_W-1:0] quo,
  output logic                      ovf
);
  import gae_pkg::*;

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] nreg;
  logic [DEN_W-1:0] dreg;
  logic [DEN_W-1:0] rem;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [DEN_W:0]   trial;
  logic             fits;

  assign trial = {rem, nreg[NUM_W-1]};
  assign fits  = trial >= {1'b0, dreg};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NUM_W);
        nreg <= num;
        dreg <= den;
        rem  <= '0;
        quo  <= '0;
        ovf  <= 1'b0;
      end else if (busy) begin
        rem  <= fits ? DEN_W'(trial - {1'b0, dreg}) : trial[DEN_W-1:0];
        quo  <= {quo[QUO_W-2:0], fits};
        ovf  <= ovf | quo[QUO_W-1];
        nreg <= nreg << 1;
        cnt  <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- src/gae_serial_sqrt.sv -----
// ----------------------------------------------------------------------------
// gae_serial_sqrt
// Digit-by-digit integer square root, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module gae_serial_sqrt (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [gae_pkg::QUO_W-1:0] radicand,
  output logic                      done,
  output logic [15:0]               root
);
  import gae_pkg::*;

  logic [31:0] rad;
  logic [18:0] rem;
  logic [4:0]  cnt;
  logic        busy;
  logic [18:0] cur;
  logic [18:0] trial;
  logic        fits;

  assign cur   = {rem[16:0], rad[31:30]};
  assign trial = {1'b0, root, 2'b01};
  assign fits  = cur >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 5'd16;
        rad  <= 32'(radicand);
        rem  <= '0;
        root <= '0;
      end else if (busy) begin
        rem  <= fits ? cur - trial : cur;
        root <= {root[14:0], fits};
        rad  <= rad << 2;
        cnt  <= cnt - 1'b1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- src/gps_airspeed_estimator.sv -----
// ----------------------------------------------------------------------------
// gps_airspeed_estimator
// Wind-triangle airspeed estimate from attitude and GPS velocity changes.
// ----------------------------------------------------------------------------
// Usage: an input request on item (item_valid/item_ready) carries the
// fuselage unit vector, GPS velocity and air density. Each request yields
// exactly one result request on result (result_valid/result_ready) with a
// status, the filtered true airspeed and, when published, the calibrated
// airspeed. Registers are to be written over the APB port while the block
// is idle; the block itself does not enforce this. One item is worked at
// a time; item_ready is high only between items. All arithmetic runs on a
// bit-serial multiplier, a restoring divider and a square-root unit, each
// started from a sequencer. An item with too small a turn uses the three
// dot-product steps only; a published one takes fourteen products, two
// divides and two square roots.
// The finished result sits in an output register, so a stalled receiver
// only holds back the next item. Reset restores the register defaults,
// the stored vector (unit north), zero velocity and zero airspeed.
// ----------------------------------------------------------------------------
module gps_airspeed_estimator #(
  parameter int FUSE_FRAC_BITS = 14
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  gae_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_ready,
  output gae_pkg::result_t result,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [3:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import gae_pkg::*;

  localparam int NUM_W = 34 + 2 * FUSE_FRAC_BITS;
  localparam int THR_W = 15 + FUSE_FRAC_BITS;
  localparam int CMP_W = (THR_W > 34) ? THR_W : 34;
  localparam logic [31:0] ONE_F = 32'd1 << FUSE_FRAC_BITS;
  localparam logic [15:0] LF_RESET = ONE_F[15:0];

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_ISSUE = 4'b0010,
    S_WAIT  = 4'b0100,
    S_OUT   = 4'b1000
  } state_t;

  typedef enum logic [4:0] {
    STP_DOT0, STP_DOT1, STP_DOT2,
    STP_DV0, STP_DV1, STP_DV2,
    STP_DF0, STP_DF1, STP_DF2,
    STP_MSQ, STP_DIVS, STP_SQS,
    STP_G1, STP_G2, STP_FF, STP_FR,
    STP_DIVC, STP_SQC
  } step_t;

  state_t state;
  step_t  step;

  logic [14:0] cos_threshold;
  logic [14:0] max_speed;
  logic [8:0]  filter_gain;
  logic        read_only;

  logic [15:0] last_fuse [3];
  logic [15:0] last_vel  [3];
  logic [14:0] filtered_speed;

  item_t               item_q;
  logic signed [33:0]  dot_acc;
  logic [33:0]         dv2;
  logic [33:0]         df2;
  logic [29:0]         msq;
  logic [14:0]         speed;
  logic [23:0]         filt_acc;
  logic [29:0]         filt_sq;
  logic [40:0]         target;
  logic [15:0]         cas;
  logic [1:0]          res_status;

  // APB port.
  logic apb_write;
  assign pready    = 1'b1;
  assign apb_write = psel & penable & pwrite;

  always_comb begin
    unique case (paddr[3:2])
      REG_COS_THRESHOLD: prdata = 32'(cos_threshold);
      REG_MAX_SPEED:     prdata = 32'(max_speed);
      REG_FILTER_GAIN:   prdata = 32'(filter_gain);
      REG_READ_ONLY:     prdata = 32'(read_only);
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cos_threshold <= 15'd16322;
      max_speed     <= 15'd30000;
      filter_gain   <= 9'd51;
      read_only     <= 1'b0;
    end else if (apb_write) begin
      unique case (paddr[3:2])
        REG_COS_THRESHOLD: cos_threshold <= pwdata[14:0];
        REG_MAX_SPEED:     max_speed     <= pwdata[14:0];
        REG_FILTER_GAIN:   filter_gain   <= pwdata[8:0];
        REG_READ_ONLY:     read_only     <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Component views of the held item.
  logic [15:0] cur_fuse [3];
  logic [15:0] cur_vel  [3];
  logic [16:0] f_abs  [3];
  logic [16:0] lf_abs [3];
  logic [16:0] dv_abs [3];
  logic [16:0] df_abs [3];
  logic        f_neg  [3];

  assign cur_fuse[0] = item_q.fuse_x;
  assign cur_fuse[1] = item_q.fuse_y;
  assign cur_fuse[2] = item_q.fuse_z;
  assign cur_vel[0]  = item_q.vel_north;
  assign cur_vel[1]  = item_q.vel_east;
  assign cur_vel[2]  = item_q.vel_down;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      f_abs[i]  = abs17({cur_fuse[i][15], cur_fuse[i]});
      lf_abs[i] = abs17({last_fuse[i][15], last_fuse[i]});
      dv_abs[i] = abs17(17'({cur_vel[i][15], cur_vel[i]} - {last_vel[i][15], last_vel[i]}));
      df_abs[i] = abs17(17'({cur_fuse[i][15], cur_fuse[i]}
                           - {last_fuse[i][15], last_fuse[i]}));
      f_neg[i]  = cur_fuse[i][15] ^ last_fuse[i][15];
    end
  end

  // Unit control.
  logic [MUL_AW-1:0] mul_a;
  logic [MUL_BW-1:0] mul_b;
  logic [MUL_PW-1:0] mul_p;
  logic              mul_done;
  logic [NUM_W-1:0]  div_num;
  logic [DEN_W-1:0]  div_den;
  logic [QUO_W-1:0]  div_quo;
  logic              div_ovf;
  logic              div_done;
  logic [15:0]       sq_root;
  logic              sq_done;
  logic              is_div;
  logic              is_sqrt;
  logic              unit_done;
  logic [8:0]        gain_sat;

  assign gain_sat = filter_gain[8] ? 9'd256 : filter_gain;
  assign is_div   = (step == STP_DIVS) || (step == STP_DIVC);
  assign is_sqrt  = (step == STP_SQS) || (step == STP_SQC);
  assign unit_done = is_div ? div_done : (is_sqrt ? sq_done : mul_done);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (step)
      STP_DOT0: begin mul_a = 32'(f_abs[0]);  mul_b = lf_abs[0]; end
      STP_DOT1: begin mul_a = 32'(f_abs[1]);  mul_b = lf_abs[1]; end
      STP_DOT2: begin mul_a = 32'(f_abs[2]);  mul_b = lf_abs[2]; end
      STP_DV0:  begin mul_a = 32'(dv_abs[0]); mul_b = dv_abs[0]; end
      STP_DV1:  begin mul_a = 32'(dv_abs[1]); mul_b = dv_abs[1]; end
      STP_DV2:  begin mul_a = 32'(dv_abs[2]); mul_b = dv_abs[2]; end
      STP_DF0:  begin mul_a = 32'(df_abs[0]); mul_b = df_abs[0]; end
      STP_DF1:  begin mul_a = 32'(df_abs[1]); mul_b = df_abs[1]; end
      STP_DF2:  begin mul_a = 32'(df_abs[2]); mul_b = df_abs[2]; end
      STP_MSQ:  begin mul_a = 32'(max_speed); mul_b = 17'(max_speed); end
      STP_G1:   begin mul_a = 32'(speed); mul_b = 17'(gain_sat); end
      STP_G2:   begin mul_a = 32'(filtered_speed); mul_b = 17'(9'd256 - gain_sat); end
      STP_FF:   begin mul_a = 32'(filtered_speed); mul_b = 17'(filtered_speed); end
      STP_FR:   begin mul_a = 32'(filt_sq); mul_b = 17'(item_q.air_density); end
      default: ;
    endcase
  end

  always_comb begin
    if (step == STP_DIVC) begin
      div_num = NUM_W'(target);
      div_den = SEA_LEVEL_DENSITY;
    end else begin
      div_num = {dv2, {(2 * FUSE_FRAC_BITS){1'b0}}};
      div_den = df2;
    end
  end

  logic issue;
  assign issue = (state == S_ISSUE);

  gae_serial_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (issue && !is_div && !is_sqrt),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_p)
  );

  gae_serial_div #(.NUM_W(NUM_W)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (issue && is_div),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo),
    .ovf   (div_ovf)
  );

  gae_serial_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (issue && is_sqrt),
    .radicand (div_quo),
    .done     (sq_done),
    .root     (sq_root)
  );

  // Arithmetic on unit results.
  logic signed [33:0] dot_next;
  logic [33:0]        dot_mag;
  logic               turn_ok;
  logic [25:0]        filt_sum;
  logic               f_neg_cur;

  always_comb begin
    case (step)
      STP_DOT1: f_neg_cur = f_neg[1];
      STP_DOT2: f_neg_cur = f_neg[2];
      default:  f_neg_cur = f_neg[0];
    endcase
  end

  assign dot_next = f_neg_cur ? dot_acc - $signed({2'b00, mul_p[31:0]})
                              : dot_acc + $signed({2'b00, mul_p[31:0]});
  assign dot_mag  = dot_next[33] ? 34'(-dot_next) : 34'(dot_next);
  assign turn_ok  = CMP_W'(dot_mag) < CMP_W'({cos_threshold, {FUSE_FRAC_BITS{1'b0}}});
  assign filt_sum = 26'(filt_acc) + 26'(mul_p[23:0]) + 26'd128;

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      step           <= STP_DOT0;
      result_valid   <= 1'b0;
      filtered_speed <= '0;
      last_fuse[0]   <= LF_RESET;
      last_fuse[1]   <= '0;
      last_fuse[2]   <= '0;
      last_vel[0]    <= '0;
      last_vel[1]    <= '0;
      last_vel[2]    <= '0;
    end else begin
      // In S_OUT the output register is reloaded below instead.
      if (result_valid && result_ready && (state != S_OUT)) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (item_valid) begin
            item_q  <= item;
            dot_acc <= '0;
            dv2     <= '0;
            df2     <= '0;
            cas     <= '0;
            step    <= STP_DOT0;
            state   <= S_ISSUE;
          end
        end
        S_ISSUE: begin
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (unit_done) begin
            state <= S_ISSUE;
            case (step) inside
              STP_DOT0, STP_DOT1: begin
                dot_acc <= dot_next;
                step    <= step_t'(step + 1'b1);
              end
              STP_DOT2: begin
                dot_acc <= dot_next;
                if (turn_ok) begin
                  step <= STP_DV0;
                end else begin
                  res_status <= STATUS_TURN_SMALL;
                  state      <= S_OUT;
                end
              end
              STP_DV0, STP_DV1, STP_DV2: begin
                dv2  <= dv2 + mul_p[33:0];
                step <= step_t'(step + 1'b1);
              end
              STP_DF0, STP_DF1, STP_DF2: begin
                df2  <= df2 + mul_p[33:0];
                step <= step_t'(step + 1'b1);
              end
              STP_MSQ: begin
                msq <= mul_p[29:0];
                if (df2 == '0) begin
                  res_status <= STATUS_REJECTED;
                  state      <= S_OUT;
                end else begin
                  step <= STP_DIVS;
                end
              end
              STP_DIVS: begin
                // A quotient at or above max_speed squared means s >= max_speed.
                if (div_ovf || (div_quo >= QUO_W'(msq))) begin
                  res_status <= STATUS_REJECTED;
                  state      <= S_OUT;
                end else begin
                  step <= STP_SQS;
                end
              end
              STP_SQS: begin
                speed <= sq_root[14:0];
                for (int i = 0; i < 3; i++) begin
                  last_fuse[i] <= cur_fuse[i];
                  last_vel[i]  <= cur_vel[i];
                end
                if (read_only) begin
                  res_status <= STATUS_NOT_PUBLISHED;
                  state      <= S_OUT;
                end else begin
                  step <= STP_G1;
                end
              end
              STP_G1: begin
                filt_acc <= mul_p[23:0];
                step     <= STP_G2;
              end
              STP_G2: begin
                filtered_speed <= filt_sum[22:8];
                step           <= STP_FF;
              end
              STP_FF: begin
                filt_sq <= mul_p[29:0];
                step    <= STP_FR;
              end
              STP_FR: begin
                target <= mul_p[40:0];
                step   <= STP_DIVC;
              end
              STP_DIVC: begin
                step <= STP_SQC;
              end
              default: begin
                cas        <= sq_root;
                res_status <= STATUS_PUBLISHED;
                state      <= S_OUT;
              end
            endcase
          end
        end
        S_OUT: begin
          if (!result_valid || result_ready) begin
            result.status              <= res_status;
            result.tas_filtered        <= filtered_speed;
            result.calibrated_airspeed <= cas;
            result_valid               <= 1'b1;
            state                      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign item_ready = (state == S_IDLE);

endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the GPS airspeed estimator. An in-bench model
// predicts each result from the requests that the block accepts, and a
// checker compares every result request with the oldest prediction. Directed
// extremes are followed by flight-like sequences under several register
// settings and idle patterns, plus a long receiver hold-off.
// ----------------------------------------------------------------------------
module tb;
  import gae_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = 14;
  localparam int UNIT = 1 << FRAC;

  logic        clk;
  logic        rst;
  logic        item_valid;
  logic        item_ready;
  item_t       item;
  logic        result_valid;
  logic        result_ready;
  result_t     result;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  gps_airspeed_estimator #(.FUSE_FRAC_BITS(FRAC)) i_dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_ready(item_ready), .item(item),
    .result_valid(result_valid), .result_ready(result_ready), .result(result),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Register copies and estimator state of the prediction model.
  logic [14:0] cos_thr_q;
  logic [14:0] max_spd_q;
  logic [8:0]  gain_q;
  logic        ro_q;
  longint      last_fuse [3];
  longint      last_vel [3];
  logic [14:0] tas_q;

  result_t     airspeed_q[$];
  int          errors;
  int          send_idle;
  int          recv_idle;
  int          hold_cycles;

  // Flight generator state: current heading and wind.
  real         dir [3];
  int          wind [3];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("tb NOT OK");
    $finish;
  end

  function automatic result_t predict_airspeed(item_t it);
    longint            f [3];
    longint            v [3];
    longint            dot;
    longint            dvv;
    longint            dff;
    logic [127:0]      dv2;
    logic [127:0]      df2;
    logic [127:0]      rhs;
    longint unsigned   s;
    longint unsigned   t;
    longint unsigned   g;
    longint unsigned   filt;
    longint unsigned   target;
    longint unsigned   cas;
    result_t           r;
    f[0] = it.fuse_x;
    f[1] = it.fuse_y;
    f[2] = it.fuse_z;
    v[0] = it.vel_north;
    v[1] = it.vel_east;
    v[2] = it.vel_down;
    r = '0;
    r.tas_filtered = tas_q;
    dot = 0;
    for (int i = 0; i < 3; i++) dot += f[i] * last_fuse[i];
    if (dot < 0) dot = -dot;
    if (!(dot < longint'(cos_thr_q) * UNIT)) begin
      r.status = STATUS_TURN_SMALL;
      return r;
    end
    dv2 = '0;
    df2 = '0;
    for (int i = 0; i < 3; i++) begin
      dvv = v[i] - last_vel[i];
      dff = f[i] - last_fuse[i];
      dv2 += 128'(dvv * dvv);
      df2 += 128'(dff * dff);
    end
    rhs = dv2 << (2 * FRAC);
    if (df2 == 0 || 128'(max_spd_q) * 128'(max_spd_q) * df2 <= rhs) begin
      r.status = STATUS_REJECTED;
      return r;
    end
    s = 0;
    for (int b = 14; b >= 0; b--) begin
      t = s | (64'd1 << b);
      if (128'(t * t) * df2 <= rhs) s = t;
    end
    for (int i = 0; i < 3; i++) begin
      last_fuse[i] = f[i];
      last_vel[i] = v[i];
    end
    g = (gain_q > 256) ? 256 : gain_q;
    filt = ((s * g + longint'(tas_q) * (256 - g) + 128) >> 8) & 64'h7FFF;
    if (ro_q) begin
      r.status = STATUS_NOT_PUBLISHED;
      return r;
    end
    tas_q = filt[14:0];
    target = filt * filt * it.air_density;
    cas = 0;
    for (int b = 15; b >= 0; b--) begin
      t = cas | (64'd1 << b);
      if (t * t * 1225 <= target) cas = t;
    end
    if (cas > 65535) cas = 65535;
    r.status = STATUS_PUBLISHED;
    r.tas_filtered = tas_q;
    r.calibrated_airspeed = cas[15:0];
    return r;
  endfunction

  // Receiver: random idling, or a counted hold-off when one is requested.
  always @(negedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      result_ready <= 1'b0;
    end else begin
      result_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      if (airspeed_q.size() == 0) begin
        $display("%0t: result with no request pending, got %p", $realtime, result);
        errors++;
      end else begin
        if (result.status !== airspeed_q[0].status) begin
          $display("%0t: status expected %0d got %0d", $realtime,
                   airspeed_q[0].status, result.status);
          errors++;
        end
        if (result.tas_filtered !== airspeed_q[0].tas_filtered) begin
          $display("%0t: tas_filtered expected %0d got %0d", $realtime,
                   airspeed_q[0].tas_filtered, result.tas_filtered);
          errors++;
        end
        if (result.calibrated_airspeed !== airspeed_q[0].calibrated_airspeed) begin
          $display("%0t: calibrated_airspeed expected %0d got %0d", $realtime,
                   airspeed_q[0].calibrated_airspeed, result.calibrated_airspeed);
          errors++;
        end
        void'(airspeed_q.pop_front());
      end
    end
  end

  task automatic send_item(item_t it);
    while ($urandom_range(99) < send_idle) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid <= 1'b1;
    item <= it;
    do @(posedge clk); while (!item_ready);
    airspeed_q.push_back(predict_airspeed(it));
    @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, int unsigned val);
    item_valid <= 1'b0;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_COS_THRESHOLD: cos_thr_q = val[14:0];
      REG_MAX_SPEED:     max_spd_q = val[14:0];
      REG_FILTER_GAIN:   gain_q = val[8:0];
      REG_READ_ONLY:     ro_q = val[0];
      default: ;
    endcase
  endtask

  task automatic set_regs(int unsigned c, int unsigned m, int unsigned g, int unsigned r);
    write_reg(REG_COS_THRESHOLD, c);
    write_reg(REG_MAX_SPEED, m);
    write_reg(REG_FILTER_GAIN, g);
    write_reg(REG_READ_ONLY, r);
  endtask

  // Lets every pending result drain, then waits out a margin.
  task automatic drain();
    item_valid <= 1'b0;
    while (airspeed_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  function automatic int clamp(int x, int lim);
    return (x > lim) ? lim : ((x < -lim) ? -lim : x);
  endfunction

  function automatic real urand_sym();
    return ($urandom_range(20000) / 10000.0) - 1.0;
  endfunction

  // Heading change: usually a fresh direction, sometimes a slight nudge
  // that should fail the turn test.
  task automatic new_heading();
    real n;
    if ($urandom_range(99) < 20) begin
      for (int i = 0; i < 3; i++) dir[i] += urand_sym() * 0.02;
    end else begin
      for (int i = 0; i < 3; i++) dir[i] = urand_sym();
    end
    n = $sqrt(dir[0] * dir[0] + dir[1] * dir[1] + dir[2] * dir[2]);
    if (n < 0.01) begin
      dir[0] = 1.0;
      dir[1] = 0.0;
      dir[2] = 0.0;
      n = 1.0;
    end
    for (int i = 0; i < 3; i++) dir[i] /= n;
  endtask

  function automatic item_t noise_item();
    logic [127:0] raw;
    item_t        it;
    raw = {$urandom, $urandom, $urandom, $urandom};
    it = raw[$bits(item_t)-1:0];
    return it;
  endfunction

  // Velocity consistent with a constant wind and a given airspeed.
  task automatic flight_item(output item_t it);
    int tas;
    int f [3];
    int v [3];
    new_heading();
    tas = ($urandom_range(9) == 0) ? $urandom_range(32767) : $urandom_range(300, 25000);
    for (int i = 0; i < 3; i++) begin
      f[i] = clamp($rtoi(dir[i] * UNIT + (dir[i] >= 0 ? 0.5 : -0.5)), UNIT);
      v[i] = clamp($rtoi(dir[i] * tas) + wind[i], 32767);
    end
    it.fuse_x = 16'(f[0]);
    it.fuse_y = 16'(f[1]);
    it.fuse_z = 16'(f[2]);
    it.vel_north = 16'(v[0]);
    it.vel_east = 16'(v[1]);
    it.vel_down = 16'(v[2]);
    it.air_density = 11'($urandom_range(2047));
  endtask

  task automatic run_random(int n);
    item_t it;
    for (int i = 0; i < 3; i++) wind[i] = $urandom_range(10000) - 5000;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(99) < 15) it = noise_item();
      else flight_item(it);
      send_item(it);
    end
    drain();
  endtask

  task automatic test_directed();
    item_t it;
    send_idle = 0;
    recv_idle = 0;
    // Same vector as the reset heading: turn too small.
    it = '{16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 11'd1225};
    send_item(it);
    // Quarter turn to east at sea-level density: published.
    it = '{16'sd0, 16'sd16384, 16'sd0, 16'sd2000, 16'sd2000, 16'sd0, 11'd1225};
    send_item(it);
    // Extremes: first rejected as too fast, then published at zero density.
    it = '{-16'sd16384, 16'sd0, 16'sd0, 16'sd32767, -16'sd32767, 16'sd32767, 11'd2047};
    send_item(it);
    it = '{16'sd0, 16'sd0, 16'sd16384, -16'sd32768, 16'sd0, 16'sd0, 11'd0};
    send_item(it);
    // A reversed heading fails the turn test; the next item is published.
    it = '{16'sd0, 16'sd0, -16'sd16384, 16'sd100, 16'sd0, 16'sd900, 11'd0};
    send_item(it);
    it = '{16'sd16384, 16'sd0, 16'sd0, 16'sd1000, -16'sd500, 16'sd0, 11'd2047};
    send_item(it);
    drain();
    // Repeated vector passes the turn test with the widest threshold, but
    // the fuselage change is zero, so it is rejected.
    set_regs(32767, 32767, 256, 0);
    send_item(it);
    it.fuse_y = 16'sd16384;
    it.fuse_x = 16'sd0;
    send_item(it);
    drain();
    // A zero speed limit rejects every turn.
    set_regs(16384, 0, 0, 0);
    it = '{16'sd0, -16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 11'd1225};
    send_item(it);
    it = '{16'sd16384, 16'sd0, 16'sd0, 16'sd3, 16'sd0, 16'sd0, 11'd1225};
    send_item(it);
    drain();
    // Read-only keeps the filtered speed while the stored samples move.
    set_regs(16384, 32767, 511, 1);
    it = '{16'sd0, 16'sd16384, 16'sd0, 16'sd5000, 16'sd0, 16'sd0, 11'd1000};
    send_item(it);
    it = '{16'sd0, 16'sd0, 16'sd16384, 16'sd5000, 16'sd5000, 16'sd0, 11'd1000};
    send_item(it);
    drain();
    // A zero threshold never lets a turn count.
    set_regs(0, 30000, 51, 0);
    it = '{16'sd0, 16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 11'd1225};
    send_item(it);
    drain();
  endtask

  task automatic test_backpressure();
    send_idle = 0;
    recv_idle = 0;
    set_regs(16322, 30000, 51, 0);
    @(negedge clk);
    hold_cycles <= 2000;
    run_random(12);
  endtask

  task automatic test_random();
    for (int mode = 0; mode < 3; mode++) begin
      send_idle = (mode == 0) ? 29 : ((mode == 1) ? 55 : 0);
      recv_idle = (mode == 0) ? 55 : ((mode == 1) ? 29 : 0);
      set_regs(16322, 30000, 51, 0);
      run_random(110);
      set_regs(16384, 32767, 256, 0);
      run_random(110);
      set_regs(8000, 20000, 0, 1);
      run_random(110);
      set_regs($urandom_range(16384), $urandom_range(32767), $urandom_range(511), 0);
      run_random(110);
    end
  endtask

  initial begin
    rst = 1'b1;
    item_valid = 1'b0;
    item = '0;
    result_ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    errors = 0;
    send_idle = 0;
    recv_idle = 0;
    hold_cycles = 0;
    cos_thr_q = 15'd16322;
    max_spd_q = 15'd30000;
    gain_q = 9'd51;
    ro_q = 1'b0;
    last_fuse = '{UNIT, 0, 0};
    last_vel = '{0, 0, 0};
    tas_q = '0;
    dir = '{1.0, 0.0, 0.0};
    wind = '{0, 0, 0};
    repeat (12) @(negedge clk);
    rst = 1'b0;
    repeat (4) @(negedge clk);
    test_directed();
    test_backpressure();
    test_random();
    drain();
    repeat (50) @(negedge clk);
    if (errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/gae_pkg.sv
src/gae_serial_mul.sv
src/gae_serial_div.sv
src/gae_serial_sqrt.sv
src/gps_airspeed_estimator.sv
tb/tb.sv
